### hw/rtl/ult_pkg.sv
// shared types and constants for the utf-8 lambda term tokenizer
`default_nettype none

package ult_pkg;

  // widths of the payload fields
  localparam int unsigned CP_W   = 21;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned LEN_W  = 6;

  // code points with a meaning of their own
  localparam logic [CP_W-1:0] CP_MAX    = 21'h10FFFF;
  localparam logic [CP_W-1:0] CP_LAMBDA = 21'h0003BB;
  localparam logic [CP_W-1:0] CP_BSLASH = 21'h00005C;
  localparam logic [CP_W-1:0] CP_DOT    = 21'h00002E;
  localparam logic [CP_W-1:0] CP_LPAREN = 21'h000028;
  localparam logic [CP_W-1:0] CP_RPAREN = 21'h000029;
  localparam logic [CP_W-1:0] CP_SPACE  = 21'h000020;
  localparam logic [CP_W-1:0] CP_TAB    = 21'h000009;
  localparam logic [CP_W-1:0] CP_CR     = 21'h00000D;
  localparam logic [CP_W-1:0] CP_LF     = 21'h00000A;
  localparam logic [CP_W-1:0] CP_NUL    = 21'h000000;

  // token kinds on the result channel
  typedef enum logic [KIND_W-1:0] {
    TOK_END     = 3'd0,
    TOK_LAMBDA  = 3'd1,
    TOK_DOT     = 3'd2,
    TOK_LPAREN  = 3'd3,
    TOK_RPAREN  = 3'd4,
    TOK_NAME    = 3'd5,
    TOK_TOOLONG = 3'd6
  } token_kind_t;

  // character classes seen by the lexer
  typedef enum logic [2:0] {
    CLS_END    = 3'd0,
    CLS_LAMBDA = 3'd1,
    CLS_DOT    = 3'd2,
    CLS_LPAREN = 3'd3,
    CLS_RPAREN = 3'd4,
    CLS_SPACE  = 3'd5,
    CLS_IDENT  = 3'd6,
    CLS_NONE   = 3'd7
  } char_class_t;

  // one result item
  typedef struct packed {
    token_kind_t     kind;
    logic [CP_W-1:0] code_point;
    logic            name_last;
    logic            encoding_error;
    logic            run_last;
  } result_t;

  // classify one decoded code point
  function automatic char_class_t classify(input logic [CP_W-1:0] ch);
    char_class_t cls;
    if (ch == CP_SPACE || ch == CP_TAB || ch == CP_CR || ch == CP_LF) begin
      cls = CLS_SPACE;
    end else if (ch == CP_NUL) begin
      cls = CLS_END;
    end else if (ch == CP_BSLASH || ch == CP_LAMBDA) begin
      cls = CLS_LAMBDA;
    end else if (ch == CP_DOT) begin
      cls = CLS_DOT;
    end else if (ch == CP_LPAREN) begin
      cls = CLS_LPAREN;
    end else if (ch == CP_RPAREN) begin
      cls = CLS_RPAREN;
    end else begin
      cls = CLS_IDENT;
    end
    return cls;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/utf8_lambda_term_tokenizer_top.sv
// utf-8 decoder and lambda term lexer with a four-entry result queue
// each result is registered into the queue at its input byte transfer and shown from its head
// one input byte per cycle while the queue holds fewer than three results; the results of
// a byte giving two are read out by the single-entry-per-cycle read side of the result queue
// reset: synchronous active-low rst_n clears decoder, name and halt state and empties the queue
`default_nettype none

module utf8_lambda_term_tokenizer_top
  import ult_pkg::*;
#(
  parameter int unsigned MAX_NAME_CHARS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_byte
  input  wire logic [0:0]  in_tuser,   // [0] end_of_input
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [20:0] code_point, [23:21] zero
  output logic [4:0]       out_tuser,  // [2:0] token_kind, [3] name_last, [4] encoding_error
  output logic             out_tlast   // run_last
);

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_NAME_CHARS);

  // decoder and lexer state
  logic [1:0]       pend_r, pend_nxt;
  logic [CP_W-1:0]  part_r, part_nxt;
  logic [CP_W-1:0]  held_r, held_nxt;
  logic             held_vld_r, held_vld_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             halted_r, halted_nxt;

  // result queue
  result_t          q_mem [4];
  logic [1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [2:0]       cnt_r, cnt_nxt;

  logic             in_xfer, out_xfer;
  logic             eoi;
  logic [7:0]       b;
  logic             have, is_end, err;
  logic [CP_W-1:0]  ch, shifted;
  char_class_t      cls;
  result_t          res0, res1, head;
  logic [1:0]       n_push;

  assign in_xfer   = in_tvalid & in_tready;
  assign out_xfer  = out_tvalid & out_tready;
  assign in_tready = (cnt_r < 3'd3);
  assign eoi       = in_tuser[0];
  assign b         = in_tdata;
  assign shifted   = {part_r[CP_W-7:0], b[5:0]};

  // utf-8 decode of the incoming byte
  always_comb begin
    pend_nxt = pend_r;
    part_nxt = part_r;
    have     = 1'b0;
    is_end   = 1'b0;
    err      = 1'b0;
    ch       = '0;
    if (eoi) begin
      is_end   = 1'b1;
      err      = (pend_r != 2'd0);
      pend_nxt = 2'd0;
      part_nxt = '0;
    end else if (pend_r == 2'd0) begin
      if (!b[7]) begin
        ch   = {13'd0, b};
        have = 1'b1;
      end else if (b[7:5] == 3'b110) begin
        part_nxt = {16'd0, b[4:0]};
        pend_nxt = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        part_nxt = {17'd0, b[3:0]};
        pend_nxt = 2'd2;
      end else if (b[7:3] == 5'b11110 && b[2:0] <= 3'd4) begin
        part_nxt = {18'd0, b[2:0]};
        pend_nxt = 2'd3;
      end else begin
        is_end = 1'b1;
        err    = 1'b1;
      end
    end else if (b[7:6] != 2'b10) begin
      is_end   = 1'b1;
      err      = 1'b1;
      pend_nxt = 2'd0;
      part_nxt = '0;
    end else begin
      pend_nxt = pend_r - 2'd1;
      if (pend_r == 2'd1) begin
        part_nxt = '0;
        if (shifted > CP_MAX) begin
          is_end = 1'b1;
          err    = 1'b1;
        end else begin
          ch   = shifted;
          have = 1'b1;
        end
      end else begin
        part_nxt = shifted;
      end
    end
  end

  // character class of the decoded item
  always_comb begin
    if (is_end) begin
      cls = CLS_END;
    end else if (have) begin
      cls = classify(ch);
    end else begin
      cls = CLS_NONE;
    end
  end

  // lexer: name holding, flushing and token results
  always_comb begin
    held_nxt     = held_r;
    held_vld_nxt = held_vld_r;
    len_nxt      = len_r;
    halted_nxt   = halted_r;
    res0         = '{kind: TOK_END, code_point: '0, name_last: 1'b0,
                     encoding_error: 1'b0, run_last: 1'b0};
    res1         = res0;
    n_push       = 2'd0;
    if (in_xfer && !halted_r) begin
      unique case (cls)
        CLS_NONE: begin
          n_push = 2'd0;
        end
        CLS_IDENT: begin
          if (held_vld_r) begin
            if (len_r >= MAX_LEN) begin
              res0.kind    = TOK_TOOLONG;
              n_push       = 2'd1;
              halted_nxt   = 1'b1;
              held_vld_nxt = 1'b0;
              held_nxt     = '0;
              len_nxt      = '0;
            end else begin
              res0.kind       = TOK_NAME;
              res0.code_point = held_r;
              n_push          = 2'd1;
              held_nxt        = ch;
              len_nxt         = len_r + LEN_W'(1);
            end
          end else begin
            held_nxt     = ch;
            held_vld_nxt = 1'b1;
            len_nxt      = LEN_W'(1);
          end
        end
        CLS_END, CLS_LAMBDA, CLS_DOT, CLS_LPAREN, CLS_RPAREN, CLS_SPACE: begin
          // flush the held name char first
          if (held_vld_r) begin
            res0.kind       = TOK_NAME;
            res0.code_point = held_r;
            res0.name_last  = 1'b1;
            n_push          = 2'd1;
            held_vld_nxt    = 1'b0;
            held_nxt        = '0;
            len_nxt         = '0;
          end
          if (cls != CLS_SPACE) begin
            res1.kind           = token_kind_t'(cls);
            res1.encoding_error = (cls == CLS_END) && err;
            if (held_vld_r) begin
              n_push = 2'd2;
            end else begin
              res0   = res1;
              n_push = 2'd1;
            end
          end
        end
        default: begin
          n_push = 2'd0;
        end
      endcase
    end
    res0.run_last = (n_push == 2'd1);
    res1.run_last = 1'b1;
  end

  // queue pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + n_push;
    rd_ptr_nxt = rd_ptr_r + {1'b0, out_xfer};
    cnt_nxt    = cnt_r + {1'b0, n_push} - {2'd0, out_xfer};
  end

  // control state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r     <= 2'd0;
      part_r     <= '0;
      held_r     <= '0;
      held_vld_r <= 1'b0;
      len_r      <= '0;
      halted_r   <= 1'b0;
      wr_ptr_r   <= 2'd0;
      rd_ptr_r   <= 2'd0;
      cnt_r      <= 3'd0;
    end else begin
      if (in_xfer && !halted_r) begin
        pend_r <= pend_nxt;
        part_r <= part_nxt;
      end
      held_r     <= held_nxt;
      held_vld_r <= held_vld_nxt;
      len_r      <= len_nxt;
      halted_r   <= halted_nxt;
      wr_ptr_r   <= wr_ptr_nxt;
      rd_ptr_r   <= rd_ptr_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  // queue storage, up to two writes per cycle
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      q_mem[wr_ptr_r] <= res0;
    end
    if (n_push == 2'd2) begin
      q_mem[wr_ptr_r + 2'd1] <= res1;
    end
  end

  // queue head drives the result channel
  assign head       = q_mem[rd_ptr_r];
  assign out_tvalid = (cnt_r != 3'd0);
  assign out_tdata  = {3'd0, head.code_point};
  assign out_tuser  = {head.encoding_error, head.name_last, head.kind};
  assign out_tlast  = head.run_last;

endmodule

`default_nettype wire
